[design/sorted_key_index_table_assert.svh]
// Assertion macros for the sorted key index table.
`ifndef SORTED_KEY_INDEX_TABLE_ASSERT_SVH
`define SORTED_KEY_INDEX_TABLE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define SKIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SKIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/skit_pkg.sv]
// Shared types and constants of the sorted key index table.
package skit_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    localparam int KEY_W  = 64;
    localparam int REC_W  = 32;
    localparam int KCNT_W = 7;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MODIFY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUP      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_CHK,
        S_EQ,
        S_SHIFT,
        S_INS_WR,
        S_NAV,
        S_NAVW,
        S_RESP
    } skit_state_t;

    // write enables of the key and record-address memories
    typedef struct packed {
        logic key;
        logic rec;
    } skit_wen_t;

endpackage

[design/skit_if.sv]
// Channel interfaces: command, response and configuration write.
interface skit_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [skit_pkg::CMD_W-1:0]     cmd;
    logic [skit_pkg::KEY_W-1:0]     key;
    logic [skit_pkg::REC_W-1:0]     rec_addr;

    modport source (output valid, output cmd, output key, output rec_addr, input ready);
    modport sink   (input valid, input cmd, input key, input rec_addr, output ready);
endinterface

interface skit_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [skit_pkg::STAT_W-1:0]    status;
    logic [skit_pkg::REC_W-1:0]     found_addr;
    logic [skit_pkg::KCNT_W-1:0]    key_count;

    modport source (output valid, output status, output found_addr, output key_count,
                    input ready);
    modport sink   (input valid, input status, input found_addr, input key_count,
                    output ready);
endinterface

interface skit_cfg_if;
    logic valid;
    logic ready;
    logic unique_keys;

    modport source (output valid, output unique_keys, input ready);
    modport sink   (input valid, input unique_keys, output ready);
endinterface

[design/skit_ram.sv]
// Single-port-write, single-port-read memory with registered read data.
module skit_ram #(
    parameter int W = skit_pkg::KEY_W,
    parameter int DEPTH = skit_pkg::MAX_ENTRIES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[design/skit_seq.sv]
// Command sequencer: binary search, entry shift, cursor navigation and response register.
`include "sorted_key_index_table_assert.svh"

module skit_seq #(
    parameter int MAX_ENTRIES = skit_pkg::MAX_ENTRIES_DEF,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    skit_cmd_if.sink                   req,
    skit_rsp_if.source                 rsp,
    skit_cfg_if.sink                   cfg,
    output logic [IDX_W-1:0]           rd_addr,
    input  logic [skit_pkg::KEY_W-1:0] rd_key,
    input  logic [skit_pkg::REC_W-1:0] rd_rec,
    output skit_pkg::skit_wen_t        wen,
    output logic [IDX_W-1:0]           wr_addr,
    output logic [skit_pkg::KEY_W-1:0] wr_key,
    output logic [skit_pkg::REC_W-1:0] wr_rec
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    skit_pkg::skit_state_t state_reg, state_next;

    logic [skit_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [skit_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [skit_pkg::REC_W-1:0]  rec_reg, rec_next;
    logic [CNT_W-1:0]            lo_reg, lo_next;
    logic [CNT_W-1:0]            hi_reg, hi_next;
    logic [CNT_W-1:0]            mid_reg, mid_next;
    logic [IDX_W-1:0]            src_reg, src_next;
    logic [CNT_W-1:0]            rem_reg, rem_next;
    logic                        up_reg, up_next;
    logic                        pend_reg, pend_next;
    logic [IDX_W-1:0]            pend_dst_reg, pend_dst_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            cursor_reg, cursor_next;
    logic [skit_pkg::STAT_W-1:0] status_reg, status_next;
    logic [skit_pkg::REC_W-1:0]  fa_reg, fa_next;
    logic                        unique_reg, unique_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic [skit_pkg::STAT_W-1:0] rsp_status_reg, rsp_status_next;
    logic [skit_pkg::REC_W-1:0]  rsp_fa_reg, rsp_fa_next;
    logic [skit_pkg::KCNT_W-1:0] rsp_count_reg, rsp_count_next;

    // shared compare unit and helpers
    logic             key_lt, key_eq;
    logic [CNT_W-1:0] mid_c;
    logic             lo_in;
    logic             decide;
    logic             hit_c;
    logic             full_c;
    logic             dup_c;
    logic [CNT_W-1:0] nxt_c;
    logic [IDX_W-1:0] nav_idx;
    logic             rsp_free;
    logic             lo_shift;

    assign key_lt   = rd_key < key_reg;
    assign key_eq   = rd_key == key_reg;
    assign mid_c    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_in    = lo_reg < count_reg;
    assign decide   = ((state_reg == skit_pkg::S_CHK) && !lo_in)
                      || (state_reg == skit_pkg::S_EQ);
    assign hit_c    = (state_reg == skit_pkg::S_EQ) && key_eq;
    assign full_c   = count_reg >= MAX_CNT;
    assign dup_c    = unique_reg && hit_c;
    assign nxt_c    = CNT_W'(cursor_reg) + CNT_W'(1);
    assign nav_idx  = (nxt_c >= count_reg) ? '0 : nxt_c[IDX_W-1:0];
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    // the decision opens a shift pass
    assign lo_shift = decide
                      && (((cmd_reg == skit_pkg::CMD_INSERT) && !dup_c && !full_c)
                          || ((cmd_reg == skit_pkg::CMD_REMOVE) && hit_c));

    assign req.ready      = state_reg == skit_pkg::S_IDLE;
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.found_addr = rsp_fa_reg;
    assign rsp.key_count  = rsp_count_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skit_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.cmd inside {skit_pkg::CMD_INSERT, skit_pkg::CMD_REMOVE,
                                        skit_pkg::CMD_MODIFY, skit_pkg::CMD_SEARCH})
                    begin
                        state_next = skit_pkg::S_SRCH;
                    end
                    else
                    begin
                        state_next = skit_pkg::S_NAV;
                    end
                end
            end
            skit_pkg::S_SRCH:
            begin
                state_next = (lo_reg < hi_reg) ? skit_pkg::S_CMP : skit_pkg::S_CHK;
            end
            skit_pkg::S_CMP:
            begin
                state_next = skit_pkg::S_SRCH;
            end
            skit_pkg::S_CHK, skit_pkg::S_EQ:
            begin
                if ((state_reg == skit_pkg::S_CHK) && lo_in)
                begin
                    state_next = skit_pkg::S_EQ;
                end
                else
                begin
                    state_next = lo_shift ? skit_pkg::S_SHIFT : skit_pkg::S_RESP;
                end
            end
            skit_pkg::S_SHIFT:
            begin
                if (rem_reg == '0)
                begin
                    state_next = up_reg ? skit_pkg::S_INS_WR : skit_pkg::S_RESP;
                end
            end
            skit_pkg::S_INS_WR:
            begin
                state_next = skit_pkg::S_RESP;
            end
            skit_pkg::S_NAV:
            begin
                if (((cmd_reg == skit_pkg::CMD_FIRST) || (cmd_reg == skit_pkg::CMD_NEXT))
                    && (count_reg != '0))
                begin
                    state_next = skit_pkg::S_NAVW;
                end
                else
                begin
                    state_next = skit_pkg::S_RESP;
                end
            end
            skit_pkg::S_NAVW:
            begin
                state_next = skit_pkg::S_RESP;
            end
            skit_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = skit_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = skit_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        rec_next        = rec_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        src_next        = src_reg;
        rem_next        = rem_reg;
        up_next         = up_reg;
        pend_next       = pend_reg;
        pend_dst_next   = pend_dst_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        status_next     = status_reg;
        fa_next         = fa_reg;
        unique_next     = cfg.valid ? cfg.unique_keys : unique_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_fa_next     = rsp_fa_reg;
        rsp_count_next  = rsp_count_reg;
        rd_addr         = src_reg;
        wen             = '0;
        wr_addr         = lo_reg[IDX_W-1:0];
        wr_key          = key_reg;
        wr_rec          = rec_reg;

        case (state_reg)
            skit_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.cmd;
                    key_next    = req.key;
                    rec_next    = req.rec_addr;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    fa_next     = '0;
                    status_next = skit_pkg::STAT_NOTFOUND;
                end
            end
            skit_pkg::S_SRCH:
            begin
                mid_next = mid_c;
                rd_addr  = mid_c[IDX_W-1:0];
            end
            skit_pkg::S_CMP:
            begin
                if (key_lt)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            skit_pkg::S_CHK:
            begin
                rd_addr = lo_reg[IDX_W-1:0];
            end
            skit_pkg::S_SHIFT:
            begin
                // write the entry read last cycle, read the next source
                if (pend_reg)
                begin
                    wen     = '1;
                    wr_addr = pend_dst_reg;
                    wr_key  = rd_key;
                    wr_rec  = rd_rec;
                end
                if (rem_reg != '0)
                begin
                    rd_addr       = src_reg;
                    pend_next     = 1'b1;
                    pend_dst_next = up_reg ? src_reg + IDX_W'(1) : src_reg - IDX_W'(1);
                    src_next      = up_reg ? src_reg - IDX_W'(1) : src_reg + IDX_W'(1);
                    rem_next      = rem_reg - CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            skit_pkg::S_INS_WR:
            begin
                wen         = '1;
                count_next  = count_reg + CNT_W'(1);
                status_next = skit_pkg::STAT_OK;
            end
            skit_pkg::S_NAV:
            begin
                case (cmd_reg)
                    skit_pkg::CMD_FIRST:
                    begin
                        cursor_next = '0;
                        rd_addr     = '0;
                    end
                    skit_pkg::CMD_NEXT:
                    begin
                        cursor_next = (count_reg == '0) ? '0 : nav_idx;
                        rd_addr     = nav_idx;
                    end
                    default:
                    begin
                        cursor_next = cursor_reg;
                    end
                endcase
            end
            skit_pkg::S_NAVW:
            begin
                fa_next     = rd_rec;
                status_next = skit_pkg::STAT_OK;
            end
            skit_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_fa_next     = fa_reg;
                    rsp_count_next  = skit_pkg::KCNT_W'(count_reg);
                end
            end
            default:
            begin
                rd_addr = src_reg;
            end
        endcase

        // outcome of the search for insert, remove, modify and search
        if (decide)
        begin
            case (cmd_reg)
                skit_pkg::CMD_INSERT:
                begin
                    if (dup_c)
                    begin
                        status_next = skit_pkg::STAT_DUP;
                    end
                    else if (full_c)
                    begin
                        status_next = skit_pkg::STAT_FULL;
                    end
                    else
                    begin
                        rem_next  = count_reg - lo_reg;
                        src_next  = IDX_W'(count_reg - CNT_W'(1));
                        up_next   = 1'b1;
                        pend_next = 1'b0;
                    end
                end
                skit_pkg::CMD_REMOVE:
                begin
                    if (hit_c)
                    begin
                        rem_next    = count_reg - lo_reg - CNT_W'(1);
                        src_next    = IDX_W'(lo_reg + CNT_W'(1));
                        up_next     = 1'b0;
                        pend_next   = 1'b0;
                        count_next  = count_reg - CNT_W'(1);
                        status_next = skit_pkg::STAT_OK;
                    end
                end
                skit_pkg::CMD_MODIFY:
                begin
                    if (hit_c)
                    begin
                        wen.rec     = 1'b1;
                        status_next = skit_pkg::STAT_OK;
                    end
                end
                skit_pkg::CMD_SEARCH:
                begin
                    if (hit_c)
                    begin
                        fa_next     = rd_rec;
                        status_next = skit_pkg::STAT_OK;
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skit_pkg::S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            unique_reg    <= 1'b1;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            unique_reg    <= unique_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        rec_reg        <= rec_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        src_reg        <= src_next;
        rem_reg        <= rem_next;
        up_reg         <= up_next;
        pend_dst_reg   <= pend_dst_next;
        status_reg     <= status_next;
        fa_reg         <= fa_next;
        rsp_status_reg <= rsp_status_next;
        rsp_fa_reg     <= rsp_fa_next;
        rsp_count_reg  <= rsp_count_next;
    end

    `SKIT_ASSERT(a_count_max, count_reg <= MAX_CNT, "entry count above table size")
    `SKIT_ASSERT(a_key_wr_state,
        !wen.key || (state_reg == skit_pkg::S_SHIFT) || (state_reg == skit_pkg::S_INS_WR),
        "key memory written outside shift or insert")
    `SKIT_ASSERT(a_fa_zero,
        !rsp_valid_reg || (rsp_status_reg == skit_pkg::STAT_OK) || (rsp_fa_reg == '0),
        "found address not zero on failed command")
    `SKIT_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready,
        state_reg != skit_pkg::S_IDLE, "sequencer idle right after a command transfer")
    `SKIT_ASSERT_NEXT(a_shift_to_insert,
        (state_reg == skit_pkg::S_SHIFT) && (rem_reg == '0) && up_reg,
        state_reg == skit_pkg::S_INS_WR, "insert shift did not end in the new entry write")

endmodule

[design/sorted_key_index_table.sv]
// Sorted key index table: top level with key and address memories.
// Commands: search, modify, insert and remove run a binary search over the held entries;
//   insert and remove then shift the entries above the found slot; first/next read one entry.
// One command at a time: a new command is taken once the previous response is registered.
// Reset: rst_n asynchronous active low; clears count, cursor, sequencer and response
//   valid and sets unique_keys; memories are not cleared, no clearing pass is needed.
module sorted_key_index_table #(
    parameter int MAX_ENTRIES = skit_pkg::MAX_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    skit_cmd_if.sink    req,
    skit_rsp_if.source  rsp,
    skit_cfg_if.sink    cfg
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // shared memory port signals; both memories use one read and one write address
    logic [IDX_W-1:0]           rd_addr;
    logic [IDX_W-1:0]           wr_addr;
    logic [skit_pkg::KEY_W-1:0] rd_key;
    logic [skit_pkg::REC_W-1:0] rd_rec;
    logic [skit_pkg::KEY_W-1:0] wr_key;
    logic [skit_pkg::REC_W-1:0] wr_rec;
    skit_pkg::skit_wen_t        wen;

    // sequencer: search loop, shift pass, cursor and response register
    skit_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .cfg     (cfg),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_rec  (rd_rec),
        .wen     (wen),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_rec  (wr_rec)
    );

    // sorted keys, ascending from entry 0
    skit_ram #(
        .W     (skit_pkg::KEY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .clk     (clk),
        .we      (wen.key),
        .wr_addr (wr_addr),
        .wr_data (wr_key),
        .rd_addr (rd_addr),
        .rd_data (rd_key)
    );

    // record addresses, same index as the keys
    skit_ram #(
        .W     (skit_pkg::REC_W),
        .DEPTH (MAX_ENTRIES)
    ) u_rec_ram (
        .clk     (clk),
        .we      (wen.rec),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_addr (rd_addr),
        .rd_data (rd_rec)
    );

endmodule
